// ----- rtl/core/vcf_pkg.sv -----
// Package for the velocity command framer: types, codes, frame constants and byte select.
package vcf_pkg;

  localparam int unsigned VelW      = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FreshW    = 16;
  localparam int unsigned RunW      = 8;
  localparam int unsigned AgeW      = 16;
  localparam int unsigned FrameLen  = 11;
  localparam int unsigned IdxW      = $clog2(FrameLen);
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [FreshW-1:0] FreshReset = 16'd500;
  localparam logic [RunW-1:0]   RunReset   = 8'd5;
  localparam logic [AgeW-1:0]   AgeMax     = '1;

  localparam logic [ByteW-1:0] Hdr0    = 8'h53;
  localparam logic [ByteW-1:0] Hdr1    = 8'h4A;
  localparam logic [ByteW-1:0] Hdr2    = 8'h54;
  localparam logic [ByteW-1:0] Hdr3    = 8'h55;
  localparam logic [ByteW-1:0] Trailer = 8'h01;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_SEND = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRESH_LIMIT  = 1'b0,
    CFG_MAX_ZERO_RUN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VelW-1:0] x;
    logic signed [VelW-1:0] y;
    logic signed [VelW-1:0] ang;
  } triple_t;

  typedef struct packed {
    logic busy;
    logic last;
  } ser_status_t;

  function automatic logic [ByteW-1:0] frame_byte(input logic [IdxW-1:0] idx,
                                                  input triple_t t);
    logic [ByteW-1:0] b;
    b = Trailer;
    unique case (idx)
      4'd0:    b = Hdr0;
      4'd1:    b = Hdr1;
      4'd2:    b = Hdr2;
      4'd3:    b = Hdr3;
      4'd4:    b = t.x[VelW-1:ByteW];
      4'd5:    b = t.x[ByteW-1:0];
      4'd6:    b = t.y[VelW-1:ByteW];
      4'd7:    b = t.y[ByteW-1:0];
      4'd8:    b = t.ang[VelW-1:ByteW];
      4'd9:    b = t.ang[ByteW-1:0];
      default: b = Trailer;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/vcf_serializer.sv -----
// Serializer: emits a held triple's 11-byte frame, a beat per cycle unless stalled.
module vcf_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  vcf_pkg::triple_t            load_triple,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [vcf_pkg::ByteW-1:0]   out_byte,
  output logic                        out_frame_end,
  output vcf_pkg::ser_status_t        status
);

  logic                     busy_r, busy_nxt;
  logic [vcf_pkg::IdxW-1:0] idx_r, idx_nxt;
  vcf_pkg::triple_t         trip_r, trip_nxt;
  logic                     take;
  logic                     last;

  assign last = (idx_r == vcf_pkg::LastIdx);
  assign take = busy_r && !out_stall;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    trip_nxt = trip_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      trip_nxt = load_triple;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    trip_r <= trip_nxt;
  end

  assign out_valid     = busy_r;
  assign out_byte      = vcf_pkg::frame_byte(idx_r, trip_r);
  assign out_frame_end = busy_r && last;
  assign status.busy   = busy_r;
  assign status.last   = last;

endmodule

// ----- rtl/core/velocity_command_framer_core.sv -----
// Velocity command framer top level: command store, age counter, zero-run filter, framing.
// Command, tick and unused-code beats are taken at any time, including while a frame is
// going out. A send beat is taken only when the frame serializer is free or hands over
// its last byte in that cycle; its frame then leaves over 11 output beats, one per
// cycle without back-pressure. The serializer's single frame buffer sets the send rate:
// a send is not taken until the frame before it hands over its last byte. The triple of
// a send is chosen when the beat is taken, so later commands and ticks never alter a
// frame in flight. cfg_ready is always high; configuration takes effect on the next beat.
module velocity_command_framer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic signed [vcf_pkg::VelW-1:0] in_vel_x,
  input  logic signed [vcf_pkg::VelW-1:0] in_vel_y,
  input  logic signed [vcf_pkg::VelW-1:0] in_vel_ang,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vcf_pkg::ByteW-1:0]      out_byte,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vcf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [vcf_pkg::CfgDataW-1:0]   cfg_data
);

  logic [vcf_pkg::FreshW-1:0] fresh_limit_r, fresh_limit_nxt;
  logic [vcf_pkg::RunW-1:0]   max_zero_run_r, max_zero_run_nxt;
  vcf_pkg::triple_t           cmd_r, cmd_nxt;
  logic                       cmd_seen_r, cmd_seen_nxt;
  logic [vcf_pkg::AgeW-1:0]   cmd_age_r, cmd_age_nxt;
  logic [vcf_pkg::RunW-1:0]   zero_run_r, zero_run_nxt;
  vcf_pkg::triple_t           held_r, held_nxt;

  vcf_pkg::ser_status_t ser_st;
  vcf_pkg::req_t        req;
  vcf_pkg::triple_t     cand;
  vcf_pkg::triple_t     send_trip;
  logic                 fresh;
  logic                 cand_zero;
  logic [vcf_pkg::RunW:0] run_inc;
  logic                 ser_free;
  logic                 in_take;
  logic                 load;

  assign req       = vcf_pkg::req_t'(in_req_type);
  assign cfg_ready = 1'b1;
  assign ser_free  = !ser_st.busy || (ser_st.last && !out_stall);
  assign in_stall  = (req == vcf_pkg::REQ_SEND) && !ser_free;
  assign in_take   = in_valid && !in_stall;
  assign load      = in_take && (req == vcf_pkg::REQ_SEND);

  assign fresh     = cmd_seen_r && (cmd_age_r < fresh_limit_r);
  assign cand      = fresh ? cmd_r : '0;
  assign cand_zero = (cand == '0);
  assign run_inc   = {1'b0, zero_run_r} + 1'b1;

  always_comb begin
    fresh_limit_nxt  = fresh_limit_r;
    max_zero_run_nxt = max_zero_run_r;
    cmd_nxt          = cmd_r;
    cmd_seen_nxt     = cmd_seen_r;
    cmd_age_nxt      = cmd_age_r;
    zero_run_nxt     = zero_run_r;
    held_nxt         = held_r;
    send_trip        = cand;

    if (cfg_valid && cfg_ready) begin
      unique case (vcf_pkg::cfg_idx_t'(cfg_index))
        vcf_pkg::CFG_FRESH_LIMIT:  fresh_limit_nxt  = cfg_data[vcf_pkg::FreshW-1:0];
        vcf_pkg::CFG_MAX_ZERO_RUN: max_zero_run_nxt = cfg_data[vcf_pkg::RunW-1:0];
        default: ;
      endcase
    end

    if (cand_zero) begin
      if (run_inc > {1'b0, max_zero_run_r}) begin
        send_trip = cand;
      end else begin
        send_trip = held_r;
      end
    end

    if (in_take) begin
      unique case (req)
        vcf_pkg::REQ_CMD: begin
          cmd_nxt.x    = in_vel_x;
          cmd_nxt.y    = in_vel_y;
          cmd_nxt.ang  = in_vel_ang;
          cmd_seen_nxt = 1'b1;
          cmd_age_nxt  = '0;
        end
        vcf_pkg::REQ_TICK: begin
          if (cmd_age_r != vcf_pkg::AgeMax) begin
            cmd_age_nxt = cmd_age_r + 1'b1;
          end
        end
        vcf_pkg::REQ_SEND: begin
          if (cand_zero) begin
            if (run_inc > {1'b0, max_zero_run_r}) begin
              zero_run_nxt = max_zero_run_r;
            end else begin
              zero_run_nxt = run_inc[vcf_pkg::RunW-1:0];
            end
          end else begin
            zero_run_nxt = '0;
            held_nxt     = cand;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_limit_r  <= vcf_pkg::FreshReset;
      max_zero_run_r <= vcf_pkg::RunReset;
      cmd_r          <= '0;
      cmd_seen_r     <= 1'b0;
      cmd_age_r      <= '0;
      zero_run_r     <= '0;
      held_r         <= '0;
    end else begin
      fresh_limit_r  <= fresh_limit_nxt;
      max_zero_run_r <= max_zero_run_nxt;
      cmd_r          <= cmd_nxt;
      cmd_seen_r     <= cmd_seen_nxt;
      cmd_age_r      <= cmd_age_nxt;
      zero_run_r     <= zero_run_nxt;
      held_r         <= held_nxt;
    end
  end

  vcf_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .load_triple   (send_trip),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .status        (ser_st)
  );

  // a taken send starts a frame on the next cycle
  a_send_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid && !out_frame_end)
    else $error("send beat did not start a frame");

  // a send is never taken while a frame still has bytes left besides the last one
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !ser_st.busy || (ser_st.last && !out_stall))
    else $error("send taken over a frame in flight");

  // a taken command leaves the age at zero
  a_cmd_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && req == vcf_pkg::REQ_CMD |=> cmd_age_r == '0 && cmd_seen_r)
    else $error("command did not clear age");

  // the zero run never exceeds its limit after a send
  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> zero_run_r <= $past(max_zero_run_r))
    else $error("zero run above limit");

endmodule

// ----- dv/velocity_command_framer_checker.sv -----
// Checker for the velocity command framer: predicts every frame beat and compares the output.
module velocity_command_framer_checker
  import vcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic [VelW-1:0]        in_vel_x,
  input  logic [VelW-1:0]        in_vel_y,
  input  logic [VelW-1:0]        in_vel_ang,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [ByteW-1:0]       out_byte,
  input  logic                   out_frame_end,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data,
  output int                     fail_count,
  output int                     pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_beat_t;

  frame_beat_t       frame_beat_q[$];
  logic [FreshW-1:0] fresh_lim;
  logic [RunW-1:0]   run_max;
  triple_t           cmd_vel;
  triple_t           held_vel;
  logic              cmd_seen;
  logic [AgeW-1:0]   cmd_age;
  logic [RunW-1:0]   zero_run;
  int                n_fail = 0;

  task automatic queue_send_frame();
    triple_t          t;
    logic [RunW:0]    next_run;
    logic [ByteW-1:0] fb [FrameLen];
    int               k;
    t = (cmd_seen && (cmd_age < fresh_lim)) ? cmd_vel : '0;
    if (t == '0) begin
      next_run = {1'b0, zero_run} + 1'b1;
      if (next_run > {1'b0, run_max}) begin
        zero_run = run_max;
      end else begin
        zero_run = next_run[RunW-1:0];
        t = held_vel;
      end
    end else begin
      zero_run = '0;
      held_vel = t;
    end
    fb = '{Hdr0, Hdr1, Hdr2, Hdr3, t.x[15:8], t.x[7:0], t.y[15:8], t.y[7:0],
           t.ang[15:8], t.ang[7:0], Trailer};
    for (k = 0; k < FrameLen; k++) begin
      frame_beat_q.push_back({fb[k], 1'(k == FrameLen - 1)});
    end
  endtask

  task automatic note_fail(input string what, input frame_beat_t want);
    if (n_fail < 10) begin
      $display("%0t %s: exp byte %02h end %0b, got byte %02h end %0b", $realtime, what,
               want.data, want.last, out_byte, out_frame_end);
    end
    n_fail++;
  endtask

  always @(posedge clk) begin : check_edge
    frame_beat_t want;
    if (!rst_n) begin
      fresh_lim = FreshReset;
      run_max   = RunReset;
      cmd_vel   = '0;
      held_vel  = '0;
      cmd_seen  = 1'b0;
      cmd_age   = '0;
      zero_run  = '0;
      frame_beat_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_CMD: begin
            cmd_vel  = {in_vel_x, in_vel_y, in_vel_ang};
            cmd_seen = 1'b1;
            cmd_age  = '0;
          end
          REQ_TICK: begin
            if (cmd_age != AgeMax) cmd_age = cmd_age + 1'b1;
          end
          REQ_SEND: queue_send_frame();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_beat_q.size() == 0) begin
          note_fail("unexpected out beat", '0);
        end else begin
          want = frame_beat_q.pop_front();
          if (want != {out_byte, out_frame_end}) note_fail("out beat mismatch", want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRESH_LIMIT) begin
          fresh_lim = cfg_data;
        end else begin
          run_max = cfg_data[RunW-1:0];
        end
      end
    end
    pending_beats <= frame_beat_q.size();
    fail_count    <= n_fail;
  end

endmodule

// ----- dv/velocity_command_framer_core_tb.sv -----
// Testbench top for the velocity command framer: clock, reset, stimulus, back-pressure, verdict.
module velocity_command_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vcf_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_PAUSE      = 30;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_BEATS    = 42;
  localparam int BURST_SENDS    = 16;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_req_type;
  logic [VelW-1:0]     in_vel_x;
  logic [VelW-1:0]     in_vel_y;
  logic [VelW-1:0]     in_vel_ang;
  logic                out_valid;
  logic                out_stall;
  logic [ByteW-1:0]    out_byte;
  logic                out_frame_end;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending_beats;

  bit hold_req = 1'b0;
  bit no_idle  = 1'b0;
  bit tx_burst = 1'b0;
  int beats_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  velocity_command_framer_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_vel_ang   (in_vel_ang),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  velocity_command_framer_checker frame_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_vel_ang   (in_vel_ang),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_beats(pending_beats)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VelW-1:0] rand_vel();
    logic [VelW-1:0] corner [5];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 4)];
    return VelW'($urandom);
  endfunction

  task automatic put_beat(input req_t r, input logic [VelW-1:0] x, input logic [VelW-1:0] y,
                          input logic [VelW-1:0] a);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= r;
    in_vel_x    <= x;
    in_vel_y    <= y;
    in_vel_ang  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    gap = (no_idle || tx_burst || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_noise(input req_t r);
    put_beat(r, VelW'($urandom), VelW'($urandom), VelW'($urandom));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every predicted beat has left, then let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic rand_beat();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      if ($urandom_range(0, 3) == 0) put_beat(REQ_CMD, '0, '0, '0);
      else put_beat(REQ_CMD, rand_vel(), rand_vel(), rand_vel());
    end else if (r < 55) begin
      n = $urandom_range(1, 6);
      repeat (n) put_noise(REQ_TICK);
    end else if (r < 95) begin
      put_noise(REQ_SEND);
    end else begin
      put_noise(REQ_NONE);
    end
  endtask

  // receiver back-pressure, with one long hold-off per hold_req toggle
  initial begin : rx_pressure
    int  len;
    bit  hold_seen;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        len = HOLD_CYCLES;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        len = 1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        len = gap_len();
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int p;
    int target;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_NONE;
    in_vel_x    <= '0;
    in_vel_y    <= '0;
    in_vel_ang  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_FRESH_LIMIT;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no command yet, unused code, extremes, held triple over zero sends
    put_noise(REQ_SEND);
    put_beat(REQ_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_beat(REQ_CMD, 16'h7FFF, 16'h8000, 16'h0001);
    put_noise(REQ_SEND);
    put_beat(REQ_CMD, '0, '0, '0);
    repeat (3) put_noise(REQ_SEND);
    settle();
    // limit lowered below the current run
    write_reg(CFG_MAX_ZERO_RUN, 16'd1);
    put_noise(REQ_SEND);
    put_beat(REQ_CMD, 16'h8000, 16'h7FFF, 16'hFFFF);
    put_noise(REQ_SEND);
    settle();
    // freshness edge: age 2 fresh, age 3 stale
    write_reg(CFG_FRESH_LIMIT, 16'd3);
    write_reg(CFG_MAX_ZERO_RUN, 16'd0);
    put_beat(REQ_CMD, 16'h1234, 16'hEDCB, 16'h00FF);
    repeat (2) put_noise(REQ_TICK);
    put_noise(REQ_SEND);
    put_noise(REQ_TICK);
    put_noise(REQ_SEND);
    settle();
    // zero freshness limit
    write_reg(CFG_FRESH_LIMIT, 16'd0);
    put_beat(REQ_CMD, 16'h5A5A, 16'hA5A5, 16'hFF00);
    put_noise(REQ_SEND);

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: write_reg(CFG_FRESH_LIMIT, 16'hFFFF);
        1: write_reg(CFG_FRESH_LIMIT, 16'd1);
        2: write_reg(CFG_FRESH_LIMIT, 16'($urandom_range(2, 40)));
        3: write_reg(CFG_FRESH_LIMIT, 16'd0);
        4: write_reg(CFG_FRESH_LIMIT, 16'd500);
        default: write_reg(CFG_FRESH_LIMIT, 16'($urandom));
      endcase
      case (p)
        0: write_reg(CFG_MAX_ZERO_RUN, 16'd255);
        1: write_reg(CFG_MAX_ZERO_RUN, 16'd0);
        2: write_reg(CFG_MAX_ZERO_RUN, 16'($urandom_range(1, 8)));
        3: write_reg(CFG_MAX_ZERO_RUN, 16'd5);
        4: write_reg(CFG_MAX_ZERO_RUN, 16'd2);
        default: write_reg(CFG_MAX_ZERO_RUN, 16'($urandom));
      endcase
      no_idle = (p == 2);
      if (p == 4) begin
        // hold the receiver off while sends keep coming
        hold_req <= ~hold_req;
        tx_burst = 1'b1;
        repeat (BURST_SENDS) put_noise(REQ_SEND);
        tx_burst = 1'b0;
      end
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) rand_beat();
    end
    no_idle = 1'b0;

    settle();
    repeat (END_PAUSE) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
